>>> design/acu_pkg.sv
// shared types, constants and helper functions of the audio coefficient unpacker
package acu_pkg;

    localparam int FRAME_LEN   = 256;
    localparam int BAND_LEN    = 64;
    localparam int NUM_BANDS   = 4;
    localparam int BAND_LOG    = $clog2(BAND_LEN);
    localparam int IDX_W       = 8;
    localparam int POS_W       = 9;
    localparam int RAW_W       = 16;
    localparam int VAL_W       = 30;
    localparam int CNT_W       = 3;
    localparam int MAX_SLOTS   = 4;
    localparam int DENSE_W     = 5;
    localparam int DENSE_WORDS = 16;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [3:0] MODE_NIBBLE = 4'd1;
    localparam logic [3:0] MODE_DENSE  = 4'd2;
    localparam logic [3:0] MODE_BYTE   = 4'd3;
    localparam logic [3:0] MODE_SKIP12 = 4'd4;
    localparam logic [3:0] MODE_WORD   = 4'd5;
    localparam logic [3:0] MODE_SKIP6  = 4'd6;

    localparam logic [RAW_W-1:0] OFS_NIBBLE = 16'h0004;
    localparam logic [RAW_W-1:0] OFS_DENSE  = 16'h0008;
    localparam logic [RAW_W-1:0] OFS_BYTE   = 16'h0040;
    localparam logic [RAW_W-1:0] OFS_SKIP12 = 16'h0800;
    localparam logic [RAW_W-1:0] OFS_WORD   = 16'h4000;
    localparam logic [RAW_W-1:0] OFS_SKIP6  = 16'h0020;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic             valid;
        logic             ovf;
        logic [IDX_W-1:0] index;
        logic [RAW_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic [3:0]                 shift;
        logic                       frame_end;
        slot_t [MAX_SLOTS-1:0]      slot;
    } rec_t;

    typedef struct packed {
        logic       found;
        logic [1:0] band;
    } seek_t;

    function automatic logic mode_used(input logic [3:0] mode);
        return (mode >= MODE_NIBBLE) && (mode <= MODE_SKIP6);
    endfunction

    // first band at or after start whose mode carries data
    function automatic seek_t seek_band(input logic [31:0] hdr, input logic [2:0] start);
        seek_t res;
        res = '0;
        for (int b = 0; b < NUM_BANDS; b++)
        begin
            if (!res.found && (3'(b) >= start) && mode_used(hdr[31 - 8*b -: 4]))
            begin
                res.found = 1'b1;
                res.band  = 2'(b);
            end
        end
        return res;
    endfunction

endpackage

>>> design/acu_front.sv
// front end: header tracking, band sequencing and per-word decode into result records
module acu_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [acu_pkg::RAW_W-1:0]    s_tdata,   // data_word
    input  logic                         full,
    output logic                         push,
    output acu_pkg::rec_t                rec
);

    acu_pkg::phase_t                  phase_reg, phase_next;
    logic [31:0]                      hdr_reg, hdr_next;
    logic [1:0]                       band_reg, band_next;
    logic [3:0]                       mode_reg, mode_next;
    logic [3:0]                       shift_reg, shift_next;
    logic [acu_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [acu_pkg::DENSE_W-1:0]      dense_reg, dense_next;

    logic                             accept;
    logic [31:0]                      hdr_second;
    acu_pkg::seek_t                   seek_hdr, seek_data;
    logic [2:0]                       next_band;

    logic [acu_pkg::RAW_W-1:0]        val_s  [acu_pkg::MAX_SLOTS];
    logic [4:0]                       adv_s  [acu_pkg::MAX_SLOTS];
    logic                             stop_s [acu_pkg::MAX_SLOTS];
    logic [acu_pkg::CNT_W-1:0]        max_slots;
    acu_pkg::slot_t [acu_pkg::MAX_SLOTS-1:0] slots;
    logic [acu_pkg::CNT_W-1:0]        count;
    logic                             stopped;
    logic [acu_pkg::POS_W-1:0]        pos_after;
    logic [acu_pkg::DENSE_W-1:0]      dense_inc;
    logic                             done;
    logic                             frame_done;

    assign s_tready   = !full;
    assign accept     = s_tvalid && s_tready;
    // sign quirk of the second header word
    assign hdr_second = s_tdata[15] ? {16'hFFFF, s_tdata} : {hdr_reg[31:16], s_tdata};
    assign next_band  = {1'b0, band_reg} + 3'd1;
    assign seek_hdr   = acu_pkg::seek_band(hdr_second, 3'd0);
    assign seek_data  = acu_pkg::seek_band(hdr_reg, next_band);
    assign dense_inc  = dense_reg + acu_pkg::DENSE_W'(1);
    assign frame_done = done && !seek_data.found;

    // field split per mode
    always_comb
    begin
        logic [3:0] nib;
        logic [7:0] byt;
        max_slots = '0;
        for (int i = 0; i < acu_pkg::MAX_SLOTS; i++)
        begin
            val_s[i]  = '0;
            adv_s[i]  = '0;
            stop_s[i] = 1'b0;
        end
        for (int i = 0; i < acu_pkg::MAX_SLOTS; i++)
        begin
            nib = s_tdata[15 - 4*i -: 4];
            byt = s_tdata[15 - 8*(i % 2) -: 8];
            unique case (mode_reg)
                acu_pkg::MODE_NIBBLE:
                begin
                    val_s[i]  = {13'd0, nib[2:0]} - acu_pkg::OFS_NIBBLE;
                    adv_s[i]  = 5'd1;
                    stop_s[i] = nib[3];
                end
                acu_pkg::MODE_DENSE:
                begin
                    val_s[i]  = {12'd0, nib} - acu_pkg::OFS_DENSE;
                    adv_s[i]  = 5'd1;
                end
                acu_pkg::MODE_BYTE:
                begin
                    val_s[i]  = {9'd0, byt[6:0]} - acu_pkg::OFS_BYTE;
                    adv_s[i]  = 5'd1;
                    stop_s[i] = byt[7];
                end
                acu_pkg::MODE_SKIP12:
                begin
                    val_s[i]  = {4'd0, s_tdata[11:0]} - acu_pkg::OFS_SKIP12;
                    adv_s[i]  = {1'b0, s_tdata[15:12]};
                    stop_s[i] = (s_tdata[15:12] == 4'd0);
                end
                acu_pkg::MODE_WORD:
                begin
                    val_s[i]  = {1'b0, s_tdata[14:0]} - acu_pkg::OFS_WORD;
                    adv_s[i]  = 5'd1;
                    stop_s[i] = s_tdata[15];
                end
                acu_pkg::MODE_SKIP6:
                begin
                    val_s[i]  = {10'd0, byt[5:0]} - acu_pkg::OFS_SKIP6;
                    adv_s[i]  = {3'd0, byt[7:6]};
                    stop_s[i] = (byt[7:6] == 2'd0);
                end
                default:
                begin
                    val_s[i]  = '0;
                end
            endcase
        end
        unique case (mode_reg) inside
            acu_pkg::MODE_NIBBLE, acu_pkg::MODE_DENSE: max_slots = 3'd4;
            acu_pkg::MODE_BYTE, acu_pkg::MODE_SKIP6:   max_slots = 3'd2;
            acu_pkg::MODE_SKIP12, acu_pkg::MODE_WORD:  max_slots = 3'd1;
            default:                                   max_slots = 3'd0;
        endcase
    end

    // position chain over the slots of one word
    always_comb
    begin
        logic [acu_pkg::POS_W:0] sum;
        logic [acu_pkg::POS_W-1:0] p;
        sum     = '0;
        p       = pos_reg;
        count   = '0;
        stopped = 1'b0;
        slots   = '0;
        for (int i = 0; i < acu_pkg::MAX_SLOTS; i++)
        begin
            if (!stopped && (acu_pkg::CNT_W'(i) < max_slots))
            begin
                if (p < acu_pkg::POS_W'(acu_pkg::FRAME_LEN))
                begin
                    slots[i].valid = 1'b1;
                    slots[i].index = p[acu_pkg::IDX_W-1:0];
                    slots[i].value = val_s[i];
                end
                else
                begin
                    slots[i].ovf = 1'b1;
                end
                count = acu_pkg::CNT_W'(i + 1);
                if (stop_s[i])
                begin
                    stopped = 1'b1;
                end
                else
                begin
                    sum = {1'b0, p} + {{(acu_pkg::POS_W - 4){1'b0}}, adv_s[i]};
                    p   = (sum > (acu_pkg::POS_W + 1)'(acu_pkg::FRAME_LEN))
                        ? acu_pkg::POS_W'(acu_pkg::FRAME_LEN) : sum[acu_pkg::POS_W-1:0];
                end
            end
        end
        pos_after = p;
        done = stopped || !acu_pkg::mode_used(mode_reg)
            || ((mode_reg == acu_pkg::MODE_DENSE)
                && (dense_inc >= acu_pkg::DENSE_W'(acu_pkg::DENSE_WORDS)));
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            acu_pkg::PH_HDR0:
            begin
                if (accept)
                    phase_next = acu_pkg::PH_HDR1;
            end
            acu_pkg::PH_HDR1:
            begin
                if (accept)
                    phase_next = seek_hdr.found ? acu_pkg::PH_DATA : acu_pkg::PH_HDR0;
            end
            acu_pkg::PH_DATA:
            begin
                if (accept && frame_done)
                    phase_next = acu_pkg::PH_HDR0;
            end
            default:
            begin
                phase_next = acu_pkg::PH_HDR0;
            end
        endcase
    end

    // band state and record output
    always_comb
    begin
        logic [7:0] byte_sel;
        logic [1:0] load_band;
        logic       load;
        hdr_next   = hdr_reg;
        band_next  = band_reg;
        mode_next  = mode_reg;
        shift_next = shift_reg;
        pos_next   = pos_reg;
        dense_next = dense_reg;
        push       = 1'b0;
        rec        = '0;
        load       = 1'b0;
        load_band  = '0;
        unique case (phase_reg)
            acu_pkg::PH_HDR0:
            begin
                if (accept)
                    hdr_next = {s_tdata, 16'h0000};
            end
            acu_pkg::PH_HDR1:
            begin
                if (accept)
                begin
                    hdr_next = hdr_second;
                    if (seek_hdr.found)
                    begin
                        load      = 1'b1;
                        load_band = seek_hdr.band;
                    end
                    else
                    begin
                        band_next     = '0;
                        push          = 1'b1;
                        rec.count     = acu_pkg::CNT_W'(1);
                        rec.frame_end = 1'b1;
                    end
                end
            end
            acu_pkg::PH_DATA:
            begin
                if (accept)
                begin
                    push          = (count != '0) || frame_done;
                    rec.count     = (count == '0) ? acu_pkg::CNT_W'(1) : count;
                    rec.shift     = shift_reg;
                    rec.frame_end = frame_done;
                    rec.slot      = slots;
                    if (done)
                    begin
                        if (seek_data.found)
                        begin
                            load      = 1'b1;
                            load_band = seek_data.band;
                        end
                        else
                        begin
                            band_next = '0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_after;
                        if (mode_reg == acu_pkg::MODE_DENSE)
                            dense_next = dense_inc;
                    end
                end
            end
            default:
            begin
                band_next = '0;
            end
        endcase
        byte_sel = (phase_reg == acu_pkg::PH_HDR1)
            ? hdr_second[31 - 8*load_band -: 8] : hdr_reg[31 - 8*load_band -: 8];
        if (load)
        begin
            band_next  = load_band;
            mode_next  = byte_sel[7:4];
            shift_next = byte_sel[3:0];
            pos_next   = acu_pkg::POS_W'(load_band) << acu_pkg::BAND_LOG;
            dense_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= acu_pkg::PH_HDR0;
            hdr_reg   <= '0;
            band_reg  <= '0;
            mode_reg  <= '0;
            shift_reg <= '0;
            pos_reg   <= '0;
            dense_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            band_reg  <= band_next;
            mode_reg  <= mode_next;
            shift_reg <= shift_next;
            pos_reg   <= pos_next;
            dense_reg <= dense_next;
        end
    end

endmodule

>>> design/acu_fifo.sv
// short record queue between the decode front end and the write issue back end
module acu_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  acu_pkg::rec_t din,
    output logic          full,
    input  logic          pop,
    output acu_pkg::rec_t dout,
    output logic          head_valid
);

    acu_pkg::rec_t                     mem_reg [acu_pkg::FIFO_DEPTH];
    logic [acu_pkg::FIFO_PTR_W-1:0]    wr_reg, wr_next;
    logic [acu_pkg::FIFO_PTR_W-1:0]    rd_reg, rd_next;
    logic [acu_pkg::FIFO_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              do_push, do_pop;

    assign full       = (cnt_reg == acu_pkg::FIFO_CNT_W'(acu_pkg::FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign dout       = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == acu_pkg::FIFO_PTR_W'(acu_pkg::FIFO_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == acu_pkg::FIFO_PTR_W'(acu_pkg::FIFO_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + acu_pkg::FIFO_CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - acu_pkg::FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> design/acu_back.sv
// back end: one coefficient write per ready cycle from the head record
module acu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  acu_pkg::rec_t head,
    input  logic          head_valid,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,   // coef_index, coef_value, zero pad
    output logic [1:0]    m_tuser,   // write_valid, overflow
    output logic          m_tlast    // frame_end
);

    logic [1:0]                  sub_reg, sub_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        wv_reg, wv_next;
    logic                        ovf_reg, ovf_next;
    logic                        end_reg, end_next;
    logic [acu_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [acu_pkg::VAL_W-1:0]   val_reg, val_next;

    logic                        issue;
    logic                        last;
    acu_pkg::slot_t              cur;
    logic [acu_pkg::VAL_W-1:0]   val_ext;

    assign issue   = head_valid && (!out_valid_reg || m_tready);
    assign last    = (({1'b0, sub_reg} + 3'd1) >= head.count);
    assign cur     = head.slot[sub_reg];
    assign val_ext = {{(acu_pkg::VAL_W - acu_pkg::RAW_W){cur.value[acu_pkg::RAW_W-1]}}, cur.value};
    assign pop     = issue && last;

    always_comb
    begin
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        wv_next        = wv_reg;
        ovf_next       = ovf_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            sub_next       = last ? 2'd0 : sub_reg + 2'd1;
            wv_next        = cur.valid;
            ovf_next       = cur.ovf;
            end_next       = head.frame_end && last;
            idx_next       = cur.index;
            val_next       = val_ext << head.shift;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg  <= wv_next;
        ovf_reg <= ovf_next;
        end_reg <= end_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, val_reg, idx_reg};
    assign m_tuser  = {ovf_reg, wv_reg};
    assign m_tlast  = end_reg;

endmodule

>>> design/audio_coefficient_unpacker_top.sv
// top level of the audio coefficient unpacker
// Takes one 16-bit stream word per beat and gives one coefficient write beat per
// cycle while the receiver is ready. Header words give no beat, except when all
// four bands are empty, which gives a single frame-end beat. A data word gives one
// to four beats (mode 1 and 2 up to four, modes 3 and 6 up to two, modes 4 and 5
// one), and the single write port of the back end issues them one by one. The
// front end decodes a word per cycle into a two-entry record queue while that
// queue is not full, so input beats keep flowing while earlier writes drain.
module audio_coefficient_unpacker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // coef_index[7:0], coef_value[37:8], zero pad
    output logic [1:0]  m_tuser,   // write_valid, overflow
    output logic        m_tlast    // frame_end
);

    acu_pkg::rec_t push_rec;
    acu_pkg::rec_t head_rec;
    logic          push;
    logic          full;
    logic          pop;
    logic          head_valid;

    acu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .full     (full),
        .push     (push),
        .rec      (push_rec)
    );

    acu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .din        (push_rec),
        .full       (full),
        .pop        (pop),
        .dout       (head_rec),
        .head_valid (head_valid)
    );

    acu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_rec),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("record pushed into full queue");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("record popped from empty queue");

    a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && (m_tdata == 40'd0)))
        else $error("suppressed write carries payload");

    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ((head_rec.count != 3'd0) && (head_rec.count <= 3'd4)))
        else $error("queued record has bad result count");

endmodule

>>> verif/audio_coefficient_unpacker_top_test.sv
// testbench of audio_coefficient_unpacker_top: random frames checked against a coefficient predictor
`timescale 1ns / 1ps

module audio_coefficient_unpacker_top_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 65;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        wv;
        logic [7:0]  idx;
        logic [29:0] val;
        logic        fe;
        logic        ovf;
    } coef_beat_t;

    class coef_scoreboard;
        logic [31:0]     hdr;
        acu_pkg::phase_t phase;
        int unsigned     band;
        logic [3:0]      mode;
        logic [3:0]      shift;
        int unsigned     pos;
        int unsigned     dense_cnt;
        coef_beat_t      word_q[$];
        coef_beat_t      pending_q[$];
        int              errors;

        function new();
            hdr       = '0;
            phase     = acu_pkg::PH_HDR0;
            band      = 0;
            mode      = '0;
            shift     = '0;
            pos       = 0;
            dense_cnt = 0;
            errors    = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_pos(int unsigned p);
            pos = (p > acu_pkg::FRAME_LEN) ? acu_pkg::FRAME_LEN : p;
        endfunction

        function void load_band();
            logic [7:0] bb;
            bb        = 8'(hdr >> (24 - 8 * band));
            mode      = bb[7:4];
            shift     = bb[3:0];
            set_pos(band * acu_pkg::BAND_LEN);
            dense_cnt = 0;
        endfunction

        // next band with a data-carrying mode
        function bit find_band();
            while (band < acu_pkg::NUM_BANDS)
            begin
                load_band();
                if (mode >= acu_pkg::MODE_NIBBLE && mode <= acu_pkg::MODE_SKIP6)
                    return 1'b1;
                band++;
            end
            return 1'b0;
        endfunction

        function void emit(int v);
            logic [31:0] t;
            t = 32'(v) << shift;
            if (pos < acu_pkg::FRAME_LEN)
                word_q.push_back('{1'b1, 8'(pos), t[29:0], 1'b0, 1'b0});
            else
                word_q.push_back('{1'b0, 8'd0, 30'd0, 1'b0, 1'b1});
        endfunction

        function void close_frame();
            if (word_q.size() == 0)
                word_q.push_back('{1'b0, 8'd0, 30'd0, 1'b0, 1'b0});
            word_q[word_q.size() - 1].fe = 1'b1;
            phase = acu_pkg::PH_HDR0;
            band  = 0;
        endfunction

        function void note_word(logic [15:0] w);
            bit         done;
            logic [3:0] nib;
            logic [7:0] b;
            done = 1'b0;
            word_q.delete();
            case (phase)
                acu_pkg::PH_HDR1:
                begin
                    hdr   = w[15] ? {16'hFFFF, w} : {hdr[31:16], w};
                    phase = acu_pkg::PH_DATA;
                    band  = 0;
                    if (!find_band())
                        close_frame();
                end
                acu_pkg::PH_DATA:
                begin
                    case (mode)
                        acu_pkg::MODE_NIBBLE:
                            for (int i = 0; i < 4; i++)
                            begin
                                nib = 4'(w >> (12 - 4 * i));
                                emit(int'(nib[2:0]) - 4);
                                set_pos(pos + 1);
                                if (nib[3])
                                begin
                                    done = 1'b1;
                                    break;
                                end
                            end
                        acu_pkg::MODE_DENSE:
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                nib = 4'(w >> (12 - 4 * i));
                                emit(int'(nib) - 8);
                                set_pos(pos + 1);
                            end
                            dense_cnt++;
                            if (dense_cnt >= acu_pkg::DENSE_WORDS)
                                done = 1'b1;
                        end
                        acu_pkg::MODE_BYTE:
                            for (int i = 0; i < 2; i++)
                            begin
                                b = 8'(w >> (8 - 8 * i));
                                emit(int'(b[6:0]) - 'h40);
                                set_pos(pos + 1);
                                if (b[7])
                                begin
                                    done = 1'b1;
                                    break;
                                end
                            end
                        acu_pkg::MODE_SKIP12:
                        begin
                            emit(int'(w[11:0]) - 'h800);
                            if (w[15:12] == 4'd0)
                                done = 1'b1;
                            else
                                set_pos(pos + w[15:12]);
                        end
                        acu_pkg::MODE_WORD:
                        begin
                            emit(int'(w[14:0]) - 'h4000);
                            if (w[15])
                                done = 1'b1;
                            else
                                set_pos(pos + 1);
                        end
                        acu_pkg::MODE_SKIP6:
                            for (int i = 0; i < 2; i++)
                            begin
                                b = 8'(w >> (8 - 8 * i));
                                emit(int'(b[5:0]) - 'h20);
                                if (b[7:6] == 2'd0)
                                begin
                                    done = 1'b1;
                                    break;
                                end
                                set_pos(pos + b[7:6]);
                            end
                        default:
                            done = 1'b1;
                    endcase
                    if (done)
                    begin
                        band++;
                        if (!find_band())
                            close_frame();
                    end
                end
                default:
                begin
                    hdr   = {w, 16'h0000};
                    phase = acu_pkg::PH_HDR1;
                end
            endcase
            foreach (word_q[i])
                pending_q.push_back(word_q[i]);
        endfunction

        task check_beat(coef_beat_t got);
            coef_beat_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected beat wv=%0b idx=%0d val=%h fe=%0b ovf=%0b",
                                 got.wv, got.idx, got.val, got.fe, got.ovf));
                return;
            end
            want = pending_q.pop_front();
            if (got.wv !== want.wv || got.idx !== want.idx || got.val !== want.val ||
                got.fe !== want.fe || got.ovf !== want.ovf)
                report($sformatf({"got wv=%0b idx=%0d val=%h fe=%0b ovf=%0b, ",
                                  "want wv=%0b idx=%0d val=%h fe=%0b ovf=%0b"},
                                 got.wv, got.idx, got.val, got.fe, got.ovf,
                                 want.wv, want.idx, want.val, want.fe, want.ovf));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    coef_scoreboard sb;
    coef_scoreboard shadow;
    coef_beat_t     got_beat;
    int             cycles      = 0;
    int             burst_left  = 0;
    int             ready_left  = 0;
    int             ready_style = 0;
    int             ready_tick  = 0;
    logic [15:0]    directed_words[$];

    audio_coefficient_unpacker_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_beat = '{m_tuser[0], m_tdata[7:0], m_tdata[37:8], m_tlast, m_tuser[1]};
            sb.check_beat(got_beat);
        end
    end

    // receiver stall pattern in a randomly chosen style
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_style = $urandom_range(0, 3);
            ready_left  = $urandom_range(10, 60);
        end
        ready_left--;
        ready_tick++;
        case (ready_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((ready_tick % 5) < 2);
        endcase
    end

    function automatic logic [7:0] band_byte();
        logic [3:0] m;
        if ($urandom_range(0, 4) == 0)
            m = 4'($urandom_range(7, 16));
        else
            m = 4'($urandom_range(1, 6));
        return {m, 4'($urandom_range(0, 15))};
    endfunction

    // mostly well-formed words for the state the stream is in, some noise
    function automatic logic [15:0] next_word();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            return w;
        case (shadow.phase)
            acu_pkg::PH_HDR0:
                w = {band_byte(), band_byte()};
            acu_pkg::PH_HDR1:
            begin
                w     = {band_byte(), band_byte()};
                w[15] = ($urandom_range(0, 3) == 0);
            end
            default:
                case (shadow.mode)
                    acu_pkg::MODE_NIBBLE:
                        for (int i = 0; i < 4; i++)
                            w[4 * i + 3] = ($urandom_range(0, 5) == 0);
                    acu_pkg::MODE_BYTE:
                    begin
                        w[15] = ($urandom_range(0, 7) == 0);
                        w[7]  = ($urandom_range(0, 7) == 0);
                    end
                    acu_pkg::MODE_SKIP12:
                        w[15:12] = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
                    acu_pkg::MODE_WORD:
                        w[15] = ($urandom_range(0, 9) == 0);
                    default:
                        ;
                endcase
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [15:0] w);
        int gap;
        shadow.note_word(w);
        shadow.pending_q.delete();
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(w);
        burst_left--;
        @(negedge clk);
    endtask

    initial
    begin
        sb     = new();
        shadow = new();

        // all bands empty
        directed_words.push_back(16'h0000);
        directed_words.push_back(16'h7F8F);
        // sign-extended second header word, word mode at full shift, value extremes
        directed_words.push_back(16'h1F00);
        directed_words.push_back(16'h805F);
        directed_words.push_back(16'h0000);
        directed_words.push_back(16'hFFFF);
        // nibble, byte, 6-bit skip and 12-bit skip bands, last one runs past the frame
        directed_words.push_back(16'h1F30);
        directed_words.push_back(16'h6046);
        directed_words.push_back(16'h0F00);
        directed_words.push_back(16'h00FF);
        directed_words.push_back(16'h4000);
        repeat (5) directed_words.push_back(16'hF000);
        directed_words.push_back(16'h0FFF);
        // dense band
        directed_words.push_back(16'h0000);
        directed_words.push_back(16'h0020);
        directed_words.push_back(16'h0000);
        directed_words.push_back(16'hFFFF);
        directed_words.push_back(16'h8888);
        repeat (13) directed_words.push_back(16'($urandom));

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_words[i])
            send_word(directed_words[i]);
        repeat (RANDOM_WORDS)
            send_word(next_word());
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
